/* rtl/iqap_pkg.sv */
// iqap_pkg: shared types, constants and the arctangent table for iq_to_amplitude_phase
// no dependencies
package iqap_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int CORDIC_STAGES_DEF = 14;
    localparam int ATAN_TAB_LEN      = 20;
    localparam int PRE_SHIFT         = 24;
    localparam int Z_W               = 24;
    localparam int OUT_W             = 16;
    localparam int SQRT_PAD          = 10;
    localparam int PHASE_FRAC_SHIFT  = 7;

    typedef logic signed [Z_W-1:0]   z_t;
    typedef logic signed [OUT_W-1:0] phase_t;
    typedef logic [OUT_W-1:0]        amp_t;

    localparam z_t     PI_HALF_Z     = z_t'(1647099);
    localparam z_t     PHASE_ROUND   = z_t'(64);
    localparam z_t     PHASE_MAX_Z   = z_t'(25736);
    localparam z_t     PHASE_MIN_Z   = z_t'(-25736);
    localparam phase_t PHASE_MAX     = phase_t'(25736);
    localparam phase_t PHASE_MIN     = phase_t'(-25736);
    localparam phase_t FORCED_PHASE  = phase_t'(12868);
    localparam amp_t   AMP_MAX       = 16'hFFFF;

    // atan(2^-k) in units of 2^-20 rad
    function automatic z_t atan_z(input int unsigned idx);
        z_t val;
        unique case (idx)
            0:       val = z_t'(823550);
            1:       val = z_t'(486170);
            2:       val = z_t'(256879);
            3:       val = z_t'(130396);
            4:       val = z_t'(65451);
            5:       val = z_t'(32757);
            6:       val = z_t'(16383);
            7:       val = z_t'(8192);
            8:       val = z_t'(4096);
            9:       val = z_t'(2048);
            10:      val = z_t'(1024);
            11:      val = z_t'(512);
            12:      val = z_t'(256);
            13:      val = z_t'(128);
            14:      val = z_t'(64);
            15:      val = z_t'(32);
            16:      val = z_t'(16);
            17:      val = z_t'(8);
            18:      val = z_t'(4);
            19:      val = z_t'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/iq_to_amplitude_phase.sv */
// iq_to_amplitude_phase: pipelined magnitude and phase of one offset-binary I/Q pair per clock
// magnitude by a bit-per-stage square root, phase by CORDIC vectoring
// depends on iqap_pkg
//
// Takes one I/Q code pair per clock with valid/ready on both sides and gives one result per
// pair, in order. Codes are centered on mid-scale 2^(SAMPLE_BITS-1)-1. amplitude is unsigned
// Q12.4, phase is atan2(I, Q) in signed Q3.13 radians measured from the Q axis; a raw Q code of
// zero forces the phase to pi/2. The pipeline depth is set by the longer of the square root,
// which resolves one root bit per stage, and the CORDIC rotations, which run in the same
// stages. Throughput is one transfer per clock; a stalled output holds the pipeline, and
// empty stages still fill while it waits.
module iq_to_amplitude_phase
    import iqap_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_code,
    input  logic [SAMPLE_BITS-1:0] q_code,
    input  logic                   last_in,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [OUT_W-1:0]       amplitude,
    output logic signed [OUT_W-1:0] phase,
    output logic                   last_out
);

    localparam int CW    = SAMPLE_BITS + 1;
    localparam int SQW   = 2 * SAMPLE_BITS;
    localparam int RW    = 2 * SAMPLE_BITS + SQRT_PAD;
    localparam int RTW   = RW / 2;
    localparam int REMW  = RTW + 2;
    localparam int XW    = SAMPLE_BITS + 27;
    localparam int NCORE = (RTW > CORDIC_STAGES) ? RTW : CORDIC_STAGES;
    localparam int NST   = NCORE + 2;
    localparam int AW    = (RTW + 1 > OUT_W + 1) ? RTW + 1 : OUT_W + 1;
    localparam logic signed [CW-1:0] MID_CODE = CW'((1 << (SAMPLE_BITS - 1)) - 1);

    logic [NST:0]   en;
    logic [NST-1:0] v_reg;

    logic signed [XW-1:0] x_reg  [NST];
    logic signed [XW-1:0] x_next [NST];
    logic signed [XW-1:0] y_reg  [NST];
    logic signed [XW-1:0] y_next [NST];
    z_t                   z_reg  [NST];
    z_t                   z_next [NST];
    logic                 last_reg  [NST];
    logic                 last_next [NST];
    logic                 qz_reg    [NST];
    logic                 qz_next   [NST];
    logic                 cz_reg    [NST];
    logic                 cz_next   [NST];

    logic [RW-1:0]   rad_reg   [NCORE+1];
    logic [RW-1:0]   rad_next  [NCORE+1];
    logic [REMW-1:0] rem_reg   [NCORE+1];
    logic [REMW-1:0] rem_next  [NCORE+1];
    logic [RTW-1:0]  root_reg  [NCORE+1];
    logic [RTW-1:0]  root_next [NCORE+1];

    logic [SQW-1:0] isq_reg, isq_next;
    logic [SQW-1:0] qsq_reg, qsq_next;

    logic              result_valid_reg;
    amp_t              amplitude_reg, amplitude_next;
    phase_t            phase_reg, phase_next;
    logic              last_out_reg;

    // stall chain: a stage loads when empty or when the stage after it moves
    assign en[NST]      = !result_valid_reg || result_ready;
    assign sample_ready = en[0];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_en
            assign en[s] = !v_reg[s] || en[s+1];
        end
    endgenerate

    // stage 0: centering, squares, quadrant pre-rotation
    logic signed [CW-1:0]   ic, qc;
    logic signed [2*CW-1:0] i_prod, q_prod;
    logic signed [XW-1:0]   qx, iy;

    always_comb
    begin
        ic       = $signed({1'b0, i_code}) - MID_CODE;
        qc       = $signed({1'b0, q_code}) - MID_CODE;
        i_prod   = ic * ic;
        q_prod   = qc * qc;
        isq_next = i_prod[SQW-1:0];
        qsq_next = q_prod[SQW-1:0];
        qx = {{(XW - CW - PRE_SHIFT){qc[CW-1]}}, qc, {PRE_SHIFT{1'b0}}};
        iy = {{(XW - CW - PRE_SHIFT){ic[CW-1]}}, ic, {PRE_SHIFT{1'b0}}};
        if (qc[CW-1])
        begin
            if (!ic[CW-1])
            begin
                x_next[0] = iy;
                y_next[0] = -qx;
                z_next[0] = PI_HALF_Z;
            end
            else
            begin
                x_next[0] = -iy;
                y_next[0] = qx;
                z_next[0] = -PI_HALF_Z;
            end
        end
        else
        begin
            x_next[0] = qx;
            y_next[0] = iy;
            z_next[0] = '0;
        end
        last_next[0] = last_in;
        qz_next[0]   = (q_code == '0);
        cz_next[0]   = (ic == '0) && (qc == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            isq_reg <= isq_next;
            qsq_reg <= qsq_next;
        end
    end

    // stage 1: radicand
    always_comb
    begin
        rad_next[0]  = RW'({1'b0, isq_reg} + {1'b0, qsq_reg}) << SQRT_PAD;
        rem_next[0]  = '0;
        root_next[0] = '0;
        x_next[1]    = x_reg[0];
        y_next[1]    = y_reg[0];
        z_next[1]    = z_reg[0];
        last_next[1] = last_reg[0];
        qz_next[1]   = qz_reg[0];
        cz_next[1]   = cz_reg[0];
    end

    // core stages: one root bit each while k < RTW, one micro-rotation each while k < CORDIC_STAGES
    genvar k;
    generate
        for (k = 0; k < NCORE; k++) begin : g_core
            logic [REMW-1:0] sh;
            logic [REMW-1:0] sub;
            logic [REMW:0]   diff;

            always_comb
            begin
                sh   = {rem_reg[k][REMW-3:0], rad_reg[k][RW-1:RW-2]};
                sub  = {root_reg[k], 2'b01};
                diff = {1'b0, sh} - {1'b0, sub};
                if (k < RTW)
                begin
                    rad_next[k+1] = rad_reg[k] << 2;
                    if (!diff[REMW])
                    begin
                        rem_next[k+1]  = diff[REMW-1:0];
                        root_next[k+1] = {root_reg[k][RTW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k+1]  = sh;
                        root_next[k+1] = {root_reg[k][RTW-2:0], 1'b0};
                    end
                end
                else
                begin
                    rad_next[k+1]  = rad_reg[k];
                    rem_next[k+1]  = rem_reg[k];
                    root_next[k+1] = root_reg[k];
                end

                if (k < CORDIC_STAGES)
                begin
                    if (!y_reg[k+1][XW-1])
                    begin
                        x_next[k+2] = x_reg[k+1] + (y_reg[k+1] >>> k);
                        y_next[k+2] = y_reg[k+1] - (x_reg[k+1] >>> k);
                        z_next[k+2] = z_reg[k+1] + atan_z(k);
                    end
                    else
                    begin
                        x_next[k+2] = x_reg[k+1] - (y_reg[k+1] >>> k);
                        y_next[k+2] = y_reg[k+1] + (x_reg[k+1] >>> k);
                        z_next[k+2] = z_reg[k+1] - atan_z(k);
                    end
                end
                else
                begin
                    x_next[k+2] = x_reg[k+1];
                    y_next[k+2] = y_reg[k+1];
                    z_next[k+2] = z_reg[k+1];
                end
                last_next[k+2] = last_reg[k+1];
                qz_next[k+2]   = qz_reg[k+1];
                cz_next[k+2]   = cz_reg[k+1];
            end
        end
    endgenerate

    // pipeline registers
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    v_reg[s] <= (s == 0) ? sample_valid : v_reg[(s == 0) ? 0 : s - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    x_reg[s]    <= x_next[s];
                    y_reg[s]    <= y_next[s];
                    z_reg[s]    <= z_next[s];
                    last_reg[s] <= last_next[s];
                    qz_reg[s]   <= qz_next[s];
                    cz_reg[s]   <= cz_next[s];
                end
            end

            if (s > 0) begin : g_sqrt_reg
                always_ff @(posedge clk)
                begin
                    if (en[s])
                    begin
                        rad_reg[s-1]  <= rad_next[s-1];
                        rem_reg[s-1]  <= rem_next[s-1];
                        root_reg[s-1] <= root_next[s-1];
                    end
                end
            end
        end
    endgenerate

    // output stage: rounding, saturation, phase scaling and special cases
    logic [RTW:0]  root_inc;
    logic [AW-1:0] amp_wide;
    z_t            z_round;
    z_t            ph_full;

    always_comb
    begin
        root_inc = {1'b0, root_reg[NCORE]} + (RTW + 1)'(1);
        amp_wide = AW'(root_inc >> 1);
        if (amp_wide > AW'(AMP_MAX))
            amplitude_next = AMP_MAX;
        else
            amplitude_next = amp_wide[OUT_W-1:0];

        z_round = z_reg[NST-1] + PHASE_ROUND;
        ph_full = z_round >>> PHASE_FRAC_SHIFT;
        priority if (qz_reg[NST-1])
            phase_next = FORCED_PHASE;
        else if (cz_reg[NST-1])
            phase_next = '0;
        else if (ph_full > PHASE_MAX_Z)
            phase_next = PHASE_MAX;
        else if (ph_full < PHASE_MIN_Z)
            phase_next = PHASE_MIN;
        else
            phase_next = ph_full[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en[NST])
        begin
            result_valid_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST])
        begin
            amplitude_reg <= amplitude_next;
            phase_reg     <= phase_next;
            last_out_reg  <= last_reg[NST-1];
        end
    end

    assign result_valid = result_valid_reg;
    assign amplitude    = amplitude_reg;
    assign phase        = phase_reg;
    assign last_out     = last_out_reg;

    // input only blocked when every stage and the output hold an item
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (&v_reg) && result_valid && !result_ready)
        else $error("input blocked while pipeline has a free stage");

    // last stage never stalls unless the output is held
    a_last_stage_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NST-1] && !en[NST-1]) |-> (result_valid && !result_ready))
        else $error("last stage stalled without output backpressure");

    // a centered zero vector comes out as zero amplitude and zero phase
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (en[NST] && v_reg[NST-1] && cz_reg[NST-1] && !qz_reg[NST-1])
        |=> (amplitude == '0) && (phase == '0))
        else $error("zero vector gave nonzero result");

    // zero raw Q code forces the phase
    a_forced_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (en[NST] && v_reg[NST-1] && qz_reg[NST-1]) |=> (phase == FORCED_PHASE))
        else $error("phase not forced for zero Q code");

endmodule

/* test/iqap_checker.sv */
`timescale 1ns / 100ps
// iqap_checker: predicts amplitude, phase and last flag for every accepted I/Q transfer
// and compares each result transfer, in order, with the oldest prediction
// depends on iqap_pkg
module iqap_checker
    import iqap_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    input  logic                       sample_ready,
    input  logic [SAMPLE_BITS_DEF-1:0] i_code,
    input  logic [SAMPLE_BITS_DEF-1:0] q_code,
    input  logic                       last_in,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  amp_t                       amplitude,
    input  phase_t                     phase,
    input  logic                       last_out,
    output int                         fail_count,
    output int                         pending
);

    localparam longint MID_CODE   = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint UNIT_SCALE = longint'(1) <<< PRE_SHIFT;

    typedef struct packed {
        amp_t   amp;
        phase_t ang;
        logic   last;
    } polar_t;

    // atan(2^-k) in units of 2^-20 rad
    longint arctan_z [0:ATAN_TAB_LEN-1] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    polar_t polar_queue[$];
    polar_t want;
    int     errs;

    function automatic polar_t polar_of(input logic [SAMPLE_BITS_DEF-1:0] i_raw,
                                        input logic [SAMPLE_BITS_DEF-1:0] q_raw,
                                        input logic lst);
        longint          ic;
        longint          qc;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          ang;
        longint unsigned n;
        longint unsigned root;
        longint unsigned bitv;
        polar_t          r;
        ic = longint'(i_raw) - MID_CODE;
        qc = longint'(q_raw) - MID_CODE;

        // magnitude: floor square root of 1024*(ic^2+qc^2), then halve with rounding
        n = longint'(ic * ic + qc * qc) * 1024;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        root = (root + 1) >> 1;
        r.amp = (root > longint'(AMP_MAX)) ? AMP_MAX : amp_t'(root);

        if (q_raw == 0)
            ang = longint'(FORCED_PHASE);
        else if (ic == 0 && qc == 0)
            ang = 0;
        else
        begin
            x = qc * UNIT_SCALE;
            y = ic * UNIT_SCALE;
            z = 0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    dx = x;
                    x = y;
                    y = -dx;
                    z = longint'(PI_HALF_Z);
                end
                else
                begin
                    dx = x;
                    x = -y;
                    y = dx;
                    z = -longint'(PI_HALF_Z);
                end
            end
            for (int k = 0; k < CORDIC_STAGES_DEF && k < ATAN_TAB_LEN; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_z[k];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_z[k];
                end
            end
            ang = (z + longint'(PHASE_ROUND)) >>> PHASE_FRAC_SHIFT;
            if (ang > longint'(PHASE_MAX))
                ang = longint'(PHASE_MAX);
            if (ang < longint'(PHASE_MIN))
                ang = longint'(PHASE_MIN);
        end
        r.ang = phase_t'(ang);
        r.last = lst;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polar_queue.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (sample_valid && sample_ready)
                polar_queue.push_back(polar_of(i_code, q_code, last_in));
            if (result_valid && result_ready)
            begin
                if (polar_queue.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    errs++;
                end
                else
                begin
                    want = polar_queue.pop_front();
                    if (amplitude !== want.amp)
                    begin
                        $error("amplitude: expected %0d, got %0d", want.amp, amplitude);
                        errs++;
                    end
                    if (phase !== want.ang)
                    begin
                        $error("phase: expected %0d, got %0d", want.ang, phase);
                        errs++;
                    end
                    if (last_out !== want.last)
                    begin
                        $error("last_out: expected %0b, got %0b", want.last, last_out);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= polar_queue.size();
        end
    end

endmodule

/* test/tb_iq_to_amplitude_phase.sv */
`timescale 1ns / 100ps
// tb_iq_to_amplitude_phase: drives directed and random I/Q transfers with random idling
// on both channels and gives the verdict; depends on iqap_pkg, iqap_checker and the block
module tb_iq_to_amplitude_phase;
    import iqap_pkg::*;

    localparam int W          = SAMPLE_BITS_DEF;
    localparam int MID        = 2047;
    localparam int TOP_CODE   = 4095;
    localparam int RAND_ITEMS = 1800;
    localparam int IDLE_PCT   = 36;
    localparam int TAIL       = 40;
    localparam int STALL_MAX  = 1000;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_ready;
    logic [W-1:0] i_code;
    logic [W-1:0] q_code;
    logic         last_in;
    logic         result_valid;
    logic         result_ready = 1'b0;
    amp_t         amplitude;
    phase_t       phase;
    logic         last_out;
    int           fail_count;
    int           pending;
    logic         steady = 1'b0;
    int           stall_cycles = 0;

    iq_to_amplitude_phase dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .i_code       (i_code),
        .q_code       (q_code),
        .last_in      (last_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .amplitude    (amplitude),
        .phase        (phase),
        .last_out     (last_out)
    );

    iqap_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .i_code       (i_code),
        .q_code       (q_code),
        .last_in      (last_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .amplitude    (amplitude),
        .phase        (phase),
        .last_out     (last_out),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_MAX)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_sample(input int i_val, input int q_val, input logic lst);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        sample_valid <= 1'b1;
        i_code <= W'(i_val);
        q_code <= W'(q_val);
        last_in <= lst;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic int pick_edge_code();
        int r;
        r = $urandom_range(0, 6);
        case (r)
            0: return 0;
            1: return 1;
            2: return MID - 1;
            3: return MID;
            4: return MID + 1;
            5: return TOP_CODE - 1;
            default: return TOP_CODE;
        endcase
    endfunction

    initial
    begin
        int   kind;
        int   iv;
        int   qv;
        int   d;
        logic lst;
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        i_code <= '0;
        q_code <= '0;
        last_in <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, axes, zero vector, q code zero, every quadrant and pre-rotation
        send_sample(0, 0, 1'b0);
        send_sample(TOP_CODE, TOP_CODE, 1'b1);
        send_sample(0, TOP_CODE, 1'b0);
        send_sample(TOP_CODE, 0, 1'b1);
        send_sample(MID, MID, 1'b0);
        send_sample(MID, 0, 1'b0);
        send_sample(MID + 1, MID, 1'b1);
        send_sample(MID, MID + 1, 1'b0);
        send_sample(MID - 1, MID, 1'b0);
        send_sample(MID, MID - 1, 1'b1);
        send_sample(MID - 1, MID - 1, 1'b0);
        send_sample(TOP_CODE, 1, 1'b0);
        send_sample(0, 1, 1'b1);
        send_sample(1, TOP_CODE, 1'b0);
        send_sample(MID, TOP_CODE, 1'b0);
        send_sample(TOP_CODE, MID, 1'b0);
        send_sample(0, MID, 1'b1);
        send_sample(MID + 100, MID - 100, 1'b0);
        send_sample(MID - 100, MID - 100, 1'b0);
        send_sample(12'haaa, 12'h555, 1'b1);
        send_sample(12'h555, 12'haaa, 1'b0);

        // hold the sender until the pipeline is empty
        drain();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            steady = (n >= 700 && n < 1000);
            kind = $urandom_range(0, 9);
            lst = ($urandom_range(0, 7) == 0);
            if (kind <= 4)
            begin
                iv = $urandom_range(0, TOP_CODE);
                qv = $urandom_range(0, TOP_CODE);
            end
            else if (kind == 5)
            begin
                iv = MID + $urandom_range(0, 16) - 8;
                qv = MID + $urandom_range(0, 16) - 8;
            end
            else if (kind == 6)
            begin
                iv = $urandom_range(0, TOP_CODE);
                qv = $urandom_range(0, TOP_CODE);
                if ($urandom_range(0, 1))
                    iv = MID;
                else
                    qv = MID;
            end
            else if (kind == 7)
            begin
                iv = $urandom_range(0, TOP_CODE);
                qv = 0;
            end
            else if (kind == 8)
            begin
                d = $urandom_range(0, MID);
                iv = $urandom_range(0, 1) ? MID + d : MID - d;
                qv = $urandom_range(0, 1) ? MID + d : MID - d;
            end
            else
            begin
                iv = pick_edge_code();
                qv = pick_edge_code();
            end
            send_sample(iv, qv, lst);
            if (n == 1200)
                drain();
        end
        steady = 1'b0;

        drain();
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
